// ===== rtl/core/ppts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process table scheduler package
// Request and response types, operation, status and entry state codes.
// ----------------------------------------------------------------------------
package ppts_pkg;

	localparam int FUNC_W      = 2;
	localparam int SIZE_FIELD_W = 32;
	localparam int ID_W        = 5;
	localparam int STATUS_W    = 3;
	localparam int UNITS_W     = 22;
	localparam int ESTATE_W    = 2;

	// Bytes per pool unit, as a shift.
	localparam int UNIT_SHIFT  = 10;

	localparam logic [UNITS_W-1:0] POOL_RESET = 22'd1200;

	localparam logic [FUNC_W-1:0] FUNC_CREATE    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SCHEDULE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TERMINATE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE      = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL  = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_OUT_OF_MEM  = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_NONE_READY  = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_NOT_RUNNING = 3'd4;

	localparam logic [ESTATE_W-1:0] ENTRY_EMPTY   = 2'd0;
	localparam logic [ESTATE_W-1:0] ENTRY_READY   = 2'd1;
	localparam logic [ESTATE_W-1:0] ENTRY_RUNNING = 2'd2;
	localparam logic [ESTATE_W-1:0] ENTRY_DONE    = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [SIZE_FIELD_W-1:0] file_size_bytes;
		logic [ID_W-1:0]         entry_id;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [ID_W-1:0]         result_id;
		logic [SIZE_FIELD_W-1:0] result_priority;
		logic [UNITS_W-1:0]      result_memory;
		logic [UNITS_W-1:0]      memory_in_use;
	} rsp_t;

	// Per-cell command from the controller.
	typedef struct packed {
		logic live;
		logic load;
		logic run;
		logic done;
	} cell_cmd_t;

endpackage

// ===== rtl/core/ppts_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process table cell
// Holds one table entry and passes the best ready candidate to its neighbour.
// ----------------------------------------------------------------------------
module ppts_cell #(
	parameter int PRIO_W = 32,
	parameter int MEM_W  = 22,
	parameter int IDX_W  = 4,
	parameter int IDX    = 0
) (
	input  logic                            clk,
	input  ppts_pkg::cell_cmd_t             cmd,
	input  logic [PRIO_W-1:0]               load_prio,
	input  logic [MEM_W-1:0]                load_mem,
	input  logic                            prev_found,
	input  logic [PRIO_W-1:0]               prev_prio,
	input  logic [MEM_W-1:0]                prev_mem,
	input  logic [IDX_W-1:0]                prev_idx,
	output logic                            next_found,
	output logic [PRIO_W-1:0]               next_prio,
	output logic [MEM_W-1:0]                next_mem,
	output logic [IDX_W-1:0]                next_idx,
	output logic [ppts_pkg::ESTATE_W-1:0]   ent_state,
	output logic [PRIO_W-1:0]               ent_prio,
	output logic [MEM_W-1:0]                ent_mem
);

	logic [ppts_pkg::ESTATE_W-1:0] state_q;
	logic [PRIO_W-1:0]             prio_q;
	logic [MEM_W-1:0]              mem_q;
	logic                          found_q;
	logic [PRIO_W-1:0]             cprio_q;
	logic [MEM_W-1:0]              cmem_q;
	logic [IDX_W-1:0]              cidx_q;
	logic                          take;

	// A strict compare keeps the earlier entry on equal priority.
	assign take = cmd.live && (state_q == ppts_pkg::ENTRY_READY) &&
	              (!prev_found || (prio_q < prev_prio));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			state_q <= ppts_pkg::ENTRY_READY;
			prio_q  <= load_prio;
			mem_q   <= load_mem;
		end else if (cmd.run) begin
			state_q <= ppts_pkg::ENTRY_RUNNING;
		end else if (cmd.done) begin
			state_q <= ppts_pkg::ENTRY_DONE;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			found_q <= 1'b1;
			cprio_q <= prio_q;
			cmem_q  <= mem_q;
			cidx_q  <= IDX_W'(IDX);
		end else begin
			found_q <= prev_found;
			cprio_q <= prev_prio;
			cmem_q  <= prev_mem;
			cidx_q  <= prev_idx;
		end
	end

	assign next_found = found_q;
	assign next_prio  = cprio_q;
	assign next_mem   = cmem_q;
	assign next_idx   = cidx_q;
	assign ent_state  = state_q;
	assign ent_prio   = prio_q;
	assign ent_mem    = mem_q;

endmodule

// ===== rtl/core/priority_process_table_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority process table scheduler
// Non-preemptive process table with a memory pool and a cell-chain scan.
// ----------------------------------------------------------------------------
// One request is handled at a time. Create, terminate and the unused
// operation code go from acceptance to a response as the request is
// captured and then, in the execute state, checked and applied to the
// table. Schedule passes through a scan state first, since the search for
// the ready entry of lowest priority walks a chain of TABLE_DEPTH cells,
// one cell per cycle, each cell forwarding the better of its own entry
// and the candidate it receives. A waiting response does not stop the
// next request from being accepted, but that request is not completed
// until the response register is free. Entries beyond the fill count are
// never looked at, so the table needs no clearing after reset.
// ----------------------------------------------------------------------------
module priority_process_table_scheduler #(
	parameter int TABLE_DEPTH = 16,
	parameter int SIZE_WIDTH  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  ppts_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output ppts_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [ppts_pkg::UNITS_W-1:0]  cfg_wdata
);

	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int NEED_W = SIZE_WIDTH - ppts_pkg::UNIT_SHIFT;
	localparam int CMP_W  = (CNT_W > ppts_pkg::ID_W) ? CNT_W : ppts_pkg::ID_W;
	localparam int SUM_W  = ppts_pkg::UNITS_W + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0]                    state_q;
	logic [IDX_W-1:0]              scan_cnt_q;
	ppts_pkg::req_t                req_q;
	ppts_pkg::rsp_t                rsp_q;
	logic                          rsp_valid_q;
	logic [ppts_pkg::UNITS_W-1:0]  pool_q;
	logic [ppts_pkg::UNITS_W-1:0]  used_q;
	logic [CNT_W-1:0]              count_q;

	logic                          accept;
	logic                          fire;
	logic [SIZE_WIDTH-1:0]         size_m;
	logic [NEED_W-1:0]             need;
	logic [SUM_W-1:0]              sum;
	logic                          full;
	logic                          oom;
	logic                          bad_id;
	logic [IDX_W-1:0]              t_slot;
	logic [ppts_pkg::ESTATE_W-1:0] t_state;
	logic [SIZE_WIDTH-1:0]         t_prio;
	logic [NEED_W-1:0]             t_mem;

	ppts_pkg::rsp_t                res;
	logic [ppts_pkg::UNITS_W-1:0]  used_d;
	logic                          load_en;
	logic                          run_en;
	logic                          done_en;

	// Candidate chain; link 0 is the empty candidate fed into the first cell.
	logic                          link_found [0:TABLE_DEPTH];
	logic [SIZE_WIDTH-1:0]         link_prio  [0:TABLE_DEPTH];
	logic [NEED_W-1:0]             link_mem   [0:TABLE_DEPTH];
	logic [IDX_W-1:0]              link_idx   [0:TABLE_DEPTH];

	logic [ppts_pkg::ESTATE_W-1:0] cell_state [0:TABLE_DEPTH-1];
	logic [SIZE_WIDTH-1:0]         cell_prio  [0:TABLE_DEPTH-1];
	logic [NEED_W-1:0]             cell_mem   [0:TABLE_DEPTH-1];
	ppts_pkg::cell_cmd_t           cell_cmd   [0:TABLE_DEPTH-1];

	assign link_found[0] = 1'b0;
	assign link_prio[0]  = '0;
	assign link_mem[0]   = '0;
	assign link_idx[0]   = '0;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign fire      = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);

	// Create checks: table full, then the pool limit.
	assign size_m = req_q.file_size_bytes[SIZE_WIDTH-1:0];
	assign need   = size_m[SIZE_WIDTH-1:ppts_pkg::UNIT_SHIFT];
	assign sum    = {1'b0, used_q} + SUM_W'(need);
	assign full   = (count_q >= CNT_W'(TABLE_DEPTH));
	assign oom    = (sum > {1'b0, pool_q});

	// Terminate looks up one entry by its id.
	assign bad_id  = (req_q.entry_id == '0) ||
	                 (CMP_W'(req_q.entry_id) > CMP_W'(count_q));
	assign t_slot  = IDX_W'(req_q.entry_id - ppts_pkg::ID_W'(1));
	assign t_state = cell_state[t_slot];
	assign t_prio  = cell_prio[t_slot];
	assign t_mem   = cell_mem[t_slot];

	always_comb begin
		res           = '0;
		used_d        = used_q;
		load_en       = 1'b0;
		run_en        = 1'b0;
		done_en       = 1'b0;
		case (req_q.func)
			ppts_pkg::FUNC_CREATE: begin
				if (full) begin
					res.status = ppts_pkg::STATUS_TABLE_FULL;
				end else if (oom) begin
					res.status = ppts_pkg::STATUS_OUT_OF_MEM;
				end else begin
					load_en             = 1'b1;
					used_d              = sum[ppts_pkg::UNITS_W-1:0];
					res.status          = ppts_pkg::STATUS_OK;
					res.result_id       = ppts_pkg::ID_W'(count_q + CNT_W'(1));
					res.result_priority = ppts_pkg::SIZE_FIELD_W'(size_m);
					res.result_memory   = ppts_pkg::UNITS_W'(need);
				end
			end
			ppts_pkg::FUNC_SCHEDULE: begin
				if (!link_found[TABLE_DEPTH]) begin
					res.status = ppts_pkg::STATUS_NONE_READY;
				end else begin
					run_en              = 1'b1;
					res.status          = ppts_pkg::STATUS_OK;
					res.result_id       = ppts_pkg::ID_W'(
					                      {1'b0, link_idx[TABLE_DEPTH]} + (IDX_W + 1)'(1));
					res.result_priority = ppts_pkg::SIZE_FIELD_W'(link_prio[TABLE_DEPTH]);
					res.result_memory   = ppts_pkg::UNITS_W'(link_mem[TABLE_DEPTH]);
				end
			end
			ppts_pkg::FUNC_TERMINATE: begin
				if (bad_id || (t_state != ppts_pkg::ENTRY_RUNNING)) begin
					res.status = ppts_pkg::STATUS_NOT_RUNNING;
				end else begin
					done_en = 1'b1;
					if (ppts_pkg::UNITS_W'(t_mem) > used_q) begin
						used_d = '0;
					end else begin
						used_d = used_q - ppts_pkg::UNITS_W'(t_mem);
					end
					res.status          = ppts_pkg::STATUS_OK;
					res.result_id       = req_q.entry_id;
					res.result_priority = ppts_pkg::SIZE_FIELD_W'(t_prio);
					res.result_memory   = ppts_pkg::UNITS_W'(t_mem);
				end
			end
			default: begin
				res.status = ppts_pkg::STATUS_OK;
			end
		endcase
		res.memory_in_use = used_d;
	end

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			assign cell_cmd[gi].live = (CNT_W'(gi) < count_q);
			assign cell_cmd[gi].load = fire && load_en && (count_q == CNT_W'(gi));
			assign cell_cmd[gi].run  = fire && run_en &&
			                           (link_idx[TABLE_DEPTH] == IDX_W'(gi));
			assign cell_cmd[gi].done = fire && done_en && (t_slot == IDX_W'(gi));

			ppts_cell #(
				.PRIO_W (SIZE_WIDTH),
				.MEM_W  (NEED_W),
				.IDX_W  (IDX_W),
				.IDX    (gi)
			) u_cell (
				.clk        (clk),
				.cmd        (cell_cmd[gi]),
				.load_prio  (size_m),
				.load_mem   (need),
				.prev_found (link_found[gi]),
				.prev_prio  (link_prio[gi]),
				.prev_mem   (link_mem[gi]),
				.prev_idx   (link_idx[gi]),
				.next_found (link_found[gi+1]),
				.next_prio  (link_prio[gi+1]),
				.next_mem   (link_mem[gi+1]),
				.next_idx   (link_idx[gi+1]),
				.ent_state  (cell_state[gi]),
				.ent_prio   (cell_prio[gi]),
				.ent_mem    (cell_mem[gi])
			);
		end
	endgenerate

	// Sequencer. The scan state counts through the TABLE_DEPTH cells of the
	// chain, so that the chain settles after the last table change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					scan_cnt_q <= '0;
					if (accept) begin
						state_q <= (req.func == ppts_pkg::FUNC_SCHEDULE) ? ST_SCAN : ST_EXEC;
					end
				end
				ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + IDX_W'(1);
					if (scan_cnt_q == IDX_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (fire) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			pool_q      <= ppts_pkg::POOL_RESET;
			used_q      <= '0;
			count_q     <= '0;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				pool_q <= cfg_wdata;
			end
			if (fire) begin
				used_q <= used_d;
				if (load_en) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The fill count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// A successful create appends exactly one entry.
	a_create_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && load_en) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("create did not append one entry");

	// A new response only ever follows the execute step.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == ST_EXEC))
		else $error("response raised outside execute");

	// A scheduled entry comes out of a live cell of the chain.
	a_sched_live: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && run_en) |-> (CNT_W'(link_idx[TABLE_DEPTH]) < count_q))
		else $error("scan picked an entry beyond the fill count");

endmodule
